[hw/rtl/dps_pkg.sv]
// ----------------------------------------------------------------------------
// dps_pkg
// Types, constants and trig/hyperbolic tables for the diphoton selector.
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int MAX_PHOTONS   = 16;
  localparam int TABLE_ENTRIES = 1024;
  localparam int SPAN          = 4096;
  localparam int TAB_STEP      = SPAN / TABLE_ENTRIES;
  localparam int POS_W         = $clog2(MAX_PHOTONS + 1);
  localparam int TAB_W         = $clog2(TABLE_ENTRIES);
  localparam int COSH_W        = 40;
  localparam int OMC_W         = 18;
  localparam int CNT_W         = 32;
  localparam int STAGES        = 6;
  localparam int Q_DEPTH       = 2;
  localparam int QPTR_W        = $clog2(Q_DEPTH);
  localparam logic [63:0] PI_Q28 = 64'd843314857;

  typedef enum logic [3:0] {
    REG_BARREL_ETA_MAX = 4'd0,
    REG_ENDCAP_ETA_MIN = 4'd1,
    REG_ENDCAP_ETA_MAX = 4'd2,
    REG_BOTH_PT_MIN    = 4'd3,
    REG_LEAD_PT_MIN    = 4'd4,
    REG_SUBLEAD_PT_MIN = 4'd5,
    REG_MASS_LOW       = 4'd6,
    REG_MASS_HIGH      = 4'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    B_IDLE, B_LOOK, B_FSUM, B_MUL, B_ADD, B_JUDGE
  } back_state_t;

  typedef struct packed {
    logic               photon_valid;
    logic [15:0]        photon_pt;
    logic signed [11:0] photon_eta;
    logic signed [11:0] photon_phi;
    logic               last_in_event;
  } photon_t;

  typedef struct packed {
    logic [2:0]  stage_reached;
    logic [15:0] lead_pt_out;
    logic [15:0] sublead_pt_out;
    logic [3:0]  lead_position;
    logic [3:0]  sublead_position;
    logic [47:0] mass_squared;
    logic [31:0] stage_total;
  } result_t;

  typedef struct packed {
    logic [10:0] barrel_eta_max;
    logic [10:0] endcap_eta_min;
    logic [10:0] endcap_eta_max;
    logic [15:0] both_pt_min;
    logic [15:0] lead_pt_min;
    logic [15:0] sublead_pt_min;
    logic [15:0] mass_low;
    logic [15:0] mass_high;
  } cfg_t;

  typedef struct packed {
    logic        two_ok;
    logic [15:0] lead_pt;
    logic [11:0] lead_eta;
    logic [11:0] lead_phi;
    logic [3:0]  lead_slot;
    logic [15:0] second_pt;
    logic [11:0] second_eta;
    logic [11:0] second_phi;
    logic [3:0]  second_slot;
  } event_t;

  typedef logic [COSH_W-1:0] cosh_tab_t [TABLE_ENTRIES];
  typedef logic [OMC_W-1:0]  omc_tab_t  [TABLE_ENTRIES];

  localparam logic [63:0] EXP_INT [16] = '{
    64'd65536, 64'd178145, 64'd484249, 64'd1316326, 64'd3578144, 64'd9726405,
    64'd26439109, 64'd71868951, 64'd195360063, 64'd531043708, 64'd1443526462,
    64'd3923911751, 64'd10666298010, 64'd28994004059, 64'd78813874367,
    64'd214238322522
  };

  // shift-subtract quotient, used only while building the tables
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] exp_frac_q24(input logic [7:0] f);
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    y    = {40'd0, f, 16'd0};
    sum  = 64'd1 << 24;
    term = 64'd1 << 24;
    for (int n = 1; n <= 20; n++) begin
      term = udiv64((term * y) >> 24, 64'(n));
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [63:0] cosh_q16(input logic [11:0] v);
    logic [63:0] e;
    logic [63:0] inv;
    logic [63:0] c;
    e   = (EXP_INT[v[11:8]] * exp_frac_q24(v[7:0]) + (64'd1 << 23)) >> 24;
    inv = udiv64((64'd1 << 32) + (e >> 1), e);
    c   = (e + inv + 64'd1) >> 1;
    return (c < 64'd65536) ? 64'd65536 : c;
  endfunction

  function automatic logic [63:0] omc_q16(input logic [11:0] v);
    logic        neg;
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] c;
    longint      sum;
    neg  = 1'b0;
    a    = 64'(v);
    term = 64'd1 << 28;
    sum  = longint'(64'd1 << 28);
    if (a > 64'd2048) a = 64'd4096 - a;
    if (a > 64'd1024) begin
      a   = 64'd2048 - a;
      neg = 1'b1;
    end
    x  = (a * PI_Q28 + 64'd1024) >> 11;
    x2 = (x * x) >> 28;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64((term * x2) >> 28, 64'((2 * n - 1) * (2 * n)));
      if (n[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    c = (64'(sum) + 64'd2048) >> 12;
    if (c > 64'd65536) c = 64'd65536;
    return neg ? (64'd65536 + c) : (64'd65536 - c);
  endfunction

  function automatic cosh_tab_t make_cosh_tab();
    cosh_tab_t t;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      t[k] = COSH_W'(cosh_q16(12'(k * TAB_STEP)));
    end
    return t;
  endfunction

  function automatic omc_tab_t make_omc_tab();
    omc_tab_t t;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      t[k] = OMC_W'(omc_q16(12'(k * TAB_STEP)));
    end
    return t;
  endfunction

  localparam cosh_tab_t COSH_TAB = make_cosh_tab();
  localparam omc_tab_t  OMC_TAB  = make_omc_tab();

endpackage

[hw/rtl/dps_front.sv]
// ----------------------------------------------------------------------------
// dps_front
// Per-photon acceptance and top-two tracking; emits one record per event.
// ----------------------------------------------------------------------------
module dps_front (
  input  logic             clk,
  input  logic             rst,
  input  dps_pkg::cfg_t    cfg,
  input  logic             ph_valid,
  output logic             ph_stall,
  input  dps_pkg::photon_t ph,
  input  logic             q_full,
  output logic             push,
  output dps_pkg::event_t  push_ev
);

  logic [dps_pkg::POS_W-1:0] pos;
  logic [1:0]                acc_cnt;
  logic [15:0]               lead_pt, second_pt;
  logic [11:0]               lead_eta, lead_phi, second_eta, second_phi;
  logic [3:0]                lead_slot, second_slot;

  logic [1:0]  acc_cnt_next;
  logic [15:0] lead_pt_next, second_pt_next;
  logic [11:0] lead_eta_next, lead_phi_next, second_eta_next, second_phi_next;
  logic [3:0]  lead_slot_next, second_slot_next;
  logic [dps_pkg::POS_W-1:0] pos_next;
  logic [11:0] ae;
  logic        take, ok, accept;

  assign ph_stall = q_full;
  assign accept   = ph_valid && !ph_stall;

  always_comb begin
    ae   = ph.photon_eta[11] ? 12'(-ph.photon_eta) : 12'(ph.photon_eta);
    ok   = (ae < {1'b0, cfg.endcap_eta_max} && ae > {1'b0, cfg.endcap_eta_min}) ||
           ae < {1'b0, cfg.barrel_eta_max};
    take = ph.photon_valid && (pos < dps_pkg::POS_W'(dps_pkg::MAX_PHOTONS));
    acc_cnt_next     = acc_cnt;
    lead_pt_next     = lead_pt;
    lead_eta_next    = lead_eta;
    lead_phi_next    = lead_phi;
    lead_slot_next   = lead_slot;
    second_pt_next   = second_pt;
    second_eta_next  = second_eta;
    second_phi_next  = second_phi;
    second_slot_next = second_slot;
    pos_next         = pos;
    if (take) begin
      pos_next = pos + 1'b1;
      if (ok) begin
        if (acc_cnt != 2'd2) acc_cnt_next = acc_cnt + 2'd1;
        if (ph.photon_pt > lead_pt) begin
          second_pt_next   = lead_pt;
          second_eta_next  = lead_eta;
          second_phi_next  = lead_phi;
          second_slot_next = lead_slot;
          lead_pt_next     = ph.photon_pt;
          lead_eta_next    = ph.photon_eta;
          lead_phi_next    = ph.photon_phi;
          lead_slot_next   = 4'(pos);
        end else if (ph.photon_pt > second_pt) begin
          second_pt_next   = ph.photon_pt;
          second_eta_next  = ph.photon_eta;
          second_phi_next  = ph.photon_phi;
          second_slot_next = 4'(pos);
        end
      end
    end
  end

  assign push = accept && ph.last_in_event;
  always_comb begin
    push_ev.two_ok      = (acc_cnt_next == 2'd2);
    push_ev.lead_pt     = lead_pt_next;
    push_ev.lead_eta    = lead_eta_next;
    push_ev.lead_phi    = lead_phi_next;
    push_ev.lead_slot   = lead_slot_next;
    push_ev.second_pt   = second_pt_next;
    push_ev.second_eta  = second_eta_next;
    push_ev.second_phi  = second_phi_next;
    push_ev.second_slot = second_slot_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos <= '0; acc_cnt <= '0;
      lead_pt <= '0; lead_eta <= '0; lead_phi <= '0; lead_slot <= '0;
      second_pt <= '0; second_eta <= '0; second_phi <= '0; second_slot <= '0;
    end else if (accept) begin
      pos <= pos_next; acc_cnt <= acc_cnt_next;
      lead_pt <= lead_pt_next; lead_eta <= lead_eta_next;
      lead_phi <= lead_phi_next; lead_slot <= lead_slot_next;
      second_pt <= second_pt_next; second_eta <= second_eta_next;
      second_phi <= second_phi_next; second_slot <= second_slot_next;
    end
  end

endmodule

[hw/rtl/dps_queue.sv]
// ----------------------------------------------------------------------------
// dps_queue
// Short event queue between front and back.
// ----------------------------------------------------------------------------
module dps_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dps_pkg::event_t push_ev,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output dps_pkg::event_t head
);

  dps_pkg::event_t             mem [dps_pkg::Q_DEPTH];
  logic [dps_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [dps_pkg::QPTR_W:0]    count;

  assign full  = (count == (dps_pkg::QPTR_W+1)'(dps_pkg::Q_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[hw/rtl/dps_back.sv]
// ----------------------------------------------------------------------------
// dps_back
// Event judge: table lookup, mass product, cutflow and result register.
// ----------------------------------------------------------------------------
module dps_back (
  input  logic             clk,
  input  logic             rst,
  input  dps_pkg::cfg_t    cfg,
  input  logic             q_empty,
  input  dps_pkg::event_t  head,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output dps_pkg::result_t res
);

  dps_pkg::back_state_t state, state_next;
  dps_pkg::event_t      ev;

  logic [dps_pkg::COSH_W-1:0] cosh_q, f;
  logic [dps_pkg::OMC_W-1:0]  omc_q;
  logic [31:0] p, l2, s2, ml2, mh2;
  logic [55:0] pl;
  logic [47:0] ph;
  logic [47:0] m2;
  logic [dps_pkg::CNT_W-1:0] cnt [dps_pkg::STAGES];
  logic [dps_pkg::CNT_W-1:0] cnt_next [dps_pkg::STAGES];

  logic signed [12:0] de;
  logic [11:0] d, dp;
  logic [dps_pkg::TAB_W-1:0] k1, k2;
  logic [71:0] prod;
  logic [56:0] q;
  logic [2:0]  stage;
  logic        out_free, load;

  assign out_free = !res_valid || !res_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      dps_pkg::B_IDLE:  if (!q_empty) state_next = dps_pkg::B_LOOK;
      dps_pkg::B_LOOK:  state_next = dps_pkg::B_FSUM;
      dps_pkg::B_FSUM:  state_next = dps_pkg::B_MUL;
      dps_pkg::B_MUL:   state_next = dps_pkg::B_ADD;
      dps_pkg::B_ADD:   state_next = dps_pkg::B_JUDGE;
      dps_pkg::B_JUDGE: if (out_free) state_next = dps_pkg::B_IDLE;
      default: state_next = dps_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state == dps_pkg::B_IDLE) && !q_empty;
    load = (state == dps_pkg::B_JUDGE) && out_free;
  end

  always_comb begin
    de   = $signed({ev.lead_eta[11], ev.lead_eta}) - $signed({ev.second_eta[11], ev.second_eta});
    d    = de[12] ? 12'(-de) : 12'(de);
    dp   = ev.lead_phi - ev.second_phi;
    k1   = dps_pkg::TAB_W'((25'(d) * 25'(dps_pkg::TABLE_ENTRIES)) >> 12);
    k2   = dps_pkg::TAB_W'((25'(dp) * 25'(dps_pkg::TABLE_ENTRIES)) >> 12);
    prod = {16'd0, pl} + {ph, 24'd0};
    q    = 57'(prod >> 15);
  end

  always_comb begin
    stage = 3'd0;
    if (ev.two_ok && ev.lead_pt >= cfg.both_pt_min && ev.second_pt >= cfg.both_pt_min) begin
      stage = 3'd1;
      if (ev.lead_pt >= cfg.lead_pt_min) begin
        stage = 3'd2;
        if (ev.second_pt >= cfg.sublead_pt_min) begin
          stage = 3'd3;
          if (52'(l2) * 52'd25 >= 52'(m2) * 52'd4 &&
              52'(s2) * 52'd100 >= 52'(m2) * 52'd9) begin
            stage = 3'd4;
            if (m2 >= 48'(ml2) && m2 <= 48'(mh2)) stage = 3'd5;
          end
        end
      end
    end
    for (int s = 0; s < dps_pkg::STAGES; s++) begin
      cnt_next[s] = cnt[s];
      if (3'(s) <= stage && cnt[s] != '1) cnt_next[s] = cnt[s] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) ev <= head;
    if (state == dps_pkg::B_LOOK) begin
      cosh_q <= dps_pkg::COSH_TAB[k1];
      omc_q  <= dps_pkg::OMC_TAB[k2];
      p      <= ev.lead_pt * ev.second_pt;
      l2     <= ev.lead_pt * ev.lead_pt;
      s2     <= ev.second_pt * ev.second_pt;
      ml2    <= cfg.mass_low * cfg.mass_low;
      mh2    <= cfg.mass_high * cfg.mass_high;
    end
    if (state == dps_pkg::B_FSUM)
      f <= cosh_q - dps_pkg::COSH_W'(65536) + dps_pkg::COSH_W'(omc_q);
    if (state == dps_pkg::B_MUL) begin
      pl <= p * f[23:0];
      ph <= p * f[39:24];
    end
    if (state == dps_pkg::B_ADD)
      m2 <= (q[56:48] != '0) ? '1 : q[47:0];
    if (load) begin
      res.stage_reached    <= stage;
      res.lead_pt_out      <= ev.lead_pt;
      res.sublead_pt_out   <= ev.second_pt;
      res.lead_position    <= ev.lead_slot;
      res.sublead_position <= ev.second_slot;
      res.mass_squared     <= (stage >= 3'd3) ? m2 : '0;
      res.stage_total      <= cnt_next[stage];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dps_pkg::B_IDLE;
      res_valid <= 1'b0;
      for (int s = 0; s < dps_pkg::STAGES; s++) cnt[s] <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        res_valid <= 1'b1;
        for (int s = 0; s < dps_pkg::STAGES; s++) cnt[s] <= cnt_next[s];
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/diphoton_event_selector_core.sv]
// ----------------------------------------------------------------------------
// diphoton_event_selector_core
// Diphoton cutflow selector: top-two photon tracking, mass and stage judge.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  photon  | ph_valid / ph_stall | ph  (photon_t), one photon or marker a beat
//  result  | res_valid/res_stall | res (result_t), one beat per event
//  config  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  Photons are taken one per cycle; the front stalls only when the two-entry
//  event queue is full. The back takes one event at a time through table
//  lookup, factor sum, split multiply, add and saturate and judge, and pops
//  the next event only after the judge. Reset is synchronous and clears all
//  counters and per-event state; config registers return to their defaults.
// ----------------------------------------------------------------------------
module diphoton_event_selector_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             ph_valid,
  output logic             ph_stall,
  input  dps_pkg::photon_t ph,
  output logic             res_valid,
  input  logic             res_stall,
  output dps_pkg::result_t res,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [3:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  dps_pkg::cfg_t   cfg;
  dps_pkg::event_t push_ev, head;
  logic            push, pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.barrel_eta_max <= 11'd351;
      cfg.endcap_eta_min <= 11'd389;
      cfg.endcap_eta_max <= 11'd607;
      cfg.both_pt_min    <= 16'd400;
      cfg.lead_pt_min    <= 16'd640;
      cfg.sublead_pt_min <= 16'd480;
      cfg.mass_low       <= 16'd1680;
      cfg.mass_high      <= 16'd2560;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dps_pkg::REG_BARREL_ETA_MAX: cfg.barrel_eta_max <= cfg_data[10:0];
        dps_pkg::REG_ENDCAP_ETA_MIN: cfg.endcap_eta_min <= cfg_data[10:0];
        dps_pkg::REG_ENDCAP_ETA_MAX: cfg.endcap_eta_max <= cfg_data[10:0];
        dps_pkg::REG_BOTH_PT_MIN:    cfg.both_pt_min    <= cfg_data;
        dps_pkg::REG_LEAD_PT_MIN:    cfg.lead_pt_min    <= cfg_data;
        dps_pkg::REG_SUBLEAD_PT_MIN: cfg.sublead_pt_min <= cfg_data;
        dps_pkg::REG_MASS_LOW:       cfg.mass_low       <= cfg_data;
        dps_pkg::REG_MASS_HIGH:      cfg.mass_high      <= cfg_data;
        default: ;
      endcase
    end
  end

  dps_front u_front (
    .clk, .rst, .cfg, .ph_valid, .ph_stall, .ph,
    .q_full, .push, .push_ev
  );

  dps_queue u_queue (
    .clk, .rst, .push, .push_ev, .pop, .full(q_full), .empty(q_empty), .head
  );

  dps_back u_back (
    .clk, .rst, .cfg, .q_empty, .head, .pop, .res_valid, .res_stall, .res
  );

endmodule

[hw/rtl/dps_checker.sv]
// ----------------------------------------------------------------------------
// dps_checker
// Port-level checks for the diphoton selector.
// ----------------------------------------------------------------------------
module dps_checker (
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_stall,
  input dps_pkg::result_t res
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_stage: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.stage_reached <= 3'd5)
    else $error("stage out of range");

  a_mass: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.stage_reached < 3'd3 |-> res.mass_squared == '0)
    else $error("mass reported below mass stage");

endmodule

bind diphoton_event_selector_core dps_checker u_dps_checker (
  .clk, .rst, .res_valid, .res_stall, .res
);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for diphoton_event_selector_core.
// Photon beats come from a queue filled by the stimulus process. Each
// accepted beat runs through a cycle-free selector model, which queues the
// expected event result. The monitor checks each result field by field.
// Several register settings are used, the extremes among them; the photon
// channel idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 3000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             ph_valid = 1'b0;
  logic             ph_stall;
  dps_pkg::photon_t ph = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  dps_pkg::result_t res;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [3:0]       cfg_index = '0;
  logic [15:0]      cfg_data = '0;

  diphoton_event_selector_core u_top (
    .clk(clk), .rst(rst),
    .ph_valid(ph_valid), .ph_stall(ph_stall), .ph(ph),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dps_pkg::photon_t photon_q[$];
  dps_pkg::result_t result_q[$];
  int      fails = 0;
  int      idle_cycles = 0;
  bit      calm = 1'b0;
  bit      ph_fire = 1'b0;
  bit      res_fire = 1'b0;
  int      ph_gap = 0;
  int      res_hold = 0;

  // selector model state
  logic [63:0]        cosh_lut [dps_pkg::TABLE_ENTRIES];
  logic [63:0]        omc_lut  [dps_pkg::TABLE_ENTRIES];
  logic [10:0]        m_barrel, m_ec_min, m_ec_max;
  logic [15:0]        m_both, m_lead, m_sub, m_mlow, m_mhigh;
  logic [15:0]        s_lead_pt, s_sec_pt;
  logic signed [11:0] s_lead_eta, s_lead_phi, s_sec_eta, s_sec_phi;
  logic [3:0]         s_lead_slot, s_sec_slot;
  int                 s_accepted, s_pos;
  logic [31:0]        cutflow [dps_pkg::STAGES];

  localparam logic [63:0] EXP_WHOLE [16] = '{
    64'd65536, 64'd178145, 64'd484249, 64'd1316326, 64'd3578144, 64'd9726405,
    64'd26439109, 64'd71868951, 64'd195360063, 64'd531043708, 64'd1443526462,
    64'd3923911751, 64'd10666298010, 64'd28994004059, 64'd78813874367,
    64'd214238322522
  };

  function automatic logic [63:0] cosh_at(int v);
    logic [63:0] y, acc, t, e, inv, c;
    y = 64'(v % 256) << 16;
    acc = 64'd1 << 24;
    t = 64'd1 << 24;
    for (int n = 1; n <= 20; n++) begin
      t = ((t * y) >> 24) / 64'(n);
      acc += t;
    end
    e = (EXP_WHOLE[(v / 256) % 16] * acc + (64'd1 << 23)) >> 24;
    inv = ((64'd1 << 32) + e / 2) / e;
    c = (e + inv + 1) >> 1;
    return (c < 64'd65536) ? 64'd65536 : c;
  endfunction

  function automatic logic [63:0] omc_at(int v);
    int          ang;
    bit          flip;
    logic [63:0] x, x2, t, c;
    longint      acc;
    ang = v % dps_pkg::SPAN;
    flip = 1'b0;
    if (ang > 2048) ang = dps_pkg::SPAN - ang;
    if (ang > 1024) begin
      ang = 2048 - ang;
      flip = 1'b1;
    end
    x = (64'(ang) * 64'd843314857 + 64'd1024) >> 11;
    x2 = (x * x) >> 28;
    t = 64'd1 << 28;
    acc = 64'sd1 << 28;
    for (int n = 1; n <= 12; n++) begin
      t = ((t * x2) >> 28) / 64'((2 * n - 1) * (2 * n));
      if (n % 2) acc -= longint'(t);
      else acc += longint'(t);
    end
    if (acc < 0) acc = 0;
    c = (64'(acc) + 64'd2048) >> 12;
    if (c > 64'd65536) c = 64'd65536;
    return flip ? 64'd65536 + c : 64'd65536 - c;
  endfunction

  function automatic void clear_event_state();
    s_lead_pt = '0; s_lead_eta = '0; s_lead_phi = '0; s_lead_slot = '0;
    s_sec_pt = '0; s_sec_eta = '0; s_sec_phi = '0; s_sec_slot = '0;
    s_accepted = 0;
    s_pos = 0;
  endfunction

  function automatic void apply_reg(logic [3:0] idx, logic [15:0] d);
    case (idx)
      dps_pkg::REG_BARREL_ETA_MAX: m_barrel = d[10:0];
      dps_pkg::REG_ENDCAP_ETA_MIN: m_ec_min = d[10:0];
      dps_pkg::REG_ENDCAP_ETA_MAX: m_ec_max = d[10:0];
      dps_pkg::REG_BOTH_PT_MIN:    m_both = d;
      dps_pkg::REG_LEAD_PT_MIN:    m_lead = d;
      dps_pkg::REG_SUBLEAD_PT_MIN: m_sub = d;
      dps_pkg::REG_MASS_LOW:       m_mlow = d;
      dps_pkg::REG_MASS_HIGH:      m_mhigh = d;
      default: ;
    endcase
  endfunction

  function automatic logic [47:0] pair_mass();
    int           de, dp;
    logic [63:0]  f, p;
    logic [127:0] q;
    de = int'(s_lead_eta) - int'(s_sec_eta);
    if (de < 0) de = -de;
    dp = (int'(s_lead_phi) - int'(s_sec_phi)) & (dps_pkg::SPAN - 1);
    f = (cosh_lut[de / 4] - 64'd65536) + omc_lut[dp / 4];
    p = 64'(s_lead_pt) * 64'(s_sec_pt);
    q = (128'(p) * 128'(f)) >> 15;
    return (q > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : q[47:0];
  endfunction

  function automatic bit judge_photon(dps_pkg::photon_t b, output dps_pkg::result_t r);
    int          ae, stage;
    logic [63:0] m2, l2, s2;
    r = '0;
    if (b.photon_valid && s_pos < dps_pkg::MAX_PHOTONS) begin
      ae = int'(b.photon_eta);
      if (ae < 0) ae = -ae;
      if ((ae < int'(m_ec_max) && ae > int'(m_ec_min)) || ae < int'(m_barrel)) begin
        if (s_accepted < 31) s_accepted++;
        if (b.photon_pt > s_lead_pt) begin
          s_sec_pt = s_lead_pt; s_sec_eta = s_lead_eta;
          s_sec_phi = s_lead_phi; s_sec_slot = s_lead_slot;
          s_lead_pt = b.photon_pt; s_lead_eta = b.photon_eta;
          s_lead_phi = b.photon_phi; s_lead_slot = 4'(s_pos);
        end else if (b.photon_pt > s_sec_pt) begin
          s_sec_pt = b.photon_pt; s_sec_eta = b.photon_eta;
          s_sec_phi = b.photon_phi; s_sec_slot = 4'(s_pos);
        end
      end
      s_pos++;
    end
    if (!b.last_in_event) return 1'b0;
    stage = 0;
    m2 = '0;
    if (s_accepted >= 2 && s_lead_pt >= m_both && s_sec_pt >= m_both) begin
      stage = 1;
      if (s_lead_pt >= m_lead) begin
        stage = 2;
        if (s_sec_pt >= m_sub) begin
          stage = 3;
          m2 = 64'(pair_mass());
          l2 = 64'(s_lead_pt) * 64'(s_lead_pt);
          s2 = 64'(s_sec_pt) * 64'(s_sec_pt);
          if (l2 * 25 >= 4 * m2 && s2 * 100 >= 9 * m2) begin
            stage = 4;
            if (m2 >= 64'(m_mlow) * 64'(m_mlow) && m2 <= 64'(m_mhigh) * 64'(m_mhigh))
              stage = 5;
          end
        end
      end
    end
    for (int s = 0; s <= stage; s++)
      if (cutflow[s] != 32'hFFFF_FFFF) cutflow[s]++;
    r.stage_reached = 3'(stage);
    r.lead_pt_out = s_lead_pt;
    r.sublead_pt_out = s_sec_pt;
    r.lead_position = s_lead_slot;
    r.sublead_position = s_sec_slot;
    r.mass_squared = m2[47:0];
    r.stage_total = cutflow[stage];
    clear_event_state();
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  function automatic int draw_wait();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // photon driver
  always @(negedge clk) begin
    if (ph_valid && !ph_fire) begin
    end else if (ph_gap > 0) begin
      ph_gap <= ph_gap - 1;
      ph_valid <= 1'b0;
    end else if (photon_q.size() > 0) begin
      ph <= photon_q.pop_front();
      ph_valid <= 1'b1;
      ph_gap <= draw_wait();
      if ($urandom_range(0, 59) == 0) calm <= ~calm;
    end else begin
      ph_valid <= 1'b0;
    end
  end

  // result-side stall
  always @(negedge clk) begin
    if (res_fire) begin
      res_hold <= draw_wait();
      res_stall <= 1'b0;
    end else if (res_hold > 0) begin
      res_hold <= res_hold - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // acceptance, prediction, checking, watchdog
  dps_pkg::result_t want, got, pred;
  always @(posedge clk) begin
    if (rst) begin
      ph_fire <= 1'b0;
      res_fire <= 1'b0;
    end else begin
      ph_fire <= ph_valid && !ph_stall;
      res_fire <= res_valid && !res_stall;
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (ph_valid && !ph_stall && judge_photon(ph, pred)) result_q.push_back(pred);
      if (res_valid && !res_stall) begin
        got = res;
        if (result_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          fails++;
        end else begin
          want = result_q.pop_front();
          check_field("stage_reached", want.stage_reached, got.stage_reached);
          check_field("lead_pt_out", want.lead_pt_out, got.lead_pt_out);
          check_field("sublead_pt_out", want.sublead_pt_out, got.sublead_pt_out);
          check_field("lead_position", want.lead_position, got.lead_position);
          check_field("sublead_position", want.sublead_position, got.sublead_position);
          check_field("mass_squared", want.mass_squared, got.mass_squared);
          check_field("stage_total", want.stage_total, got.stage_total);
        end
      end
      if ((ph_valid && !ph_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("diphoton_event_selector_core: mismatch");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic dps_pkg::photon_t mk(bit v, logic [15:0] pt, int eta, int phi, bit last);
    dps_pkg::photon_t b;
    b.photon_valid = v;
    b.photon_pt = pt;
    b.photon_eta = 12'(eta);
    b.photon_phi = 12'(phi);
    b.last_in_event = last;
    return b;
  endfunction

  task automatic wr_reg(logic [3:0] idx, logic [15:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(int b, int emin, int emax, int both, int ld, int sb, int lo, int hi);
    wr_reg(dps_pkg::REG_BARREL_ETA_MAX, 16'(b));
    wr_reg(dps_pkg::REG_ENDCAP_ETA_MIN, 16'(emin));
    wr_reg(dps_pkg::REG_ENDCAP_ETA_MAX, 16'(emax));
    wr_reg(dps_pkg::REG_BOTH_PT_MIN, 16'(both));
    wr_reg(dps_pkg::REG_LEAD_PT_MIN, 16'(ld));
    wr_reg(dps_pkg::REG_SUBLEAD_PT_MIN, 16'(sb));
    wr_reg(dps_pkg::REG_MASS_LOW, 16'(lo));
    wr_reg(dps_pkg::REG_MASS_HIGH, 16'(hi));
  endtask

  task automatic drain();
    while (photon_q.size() > 0 || ph_valid || result_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_events(int n);
    int len, made;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) == 0) begin
        photon_q.push_back(mk(1'b0, 16'($urandom()), $urandom(), $urandom(), 1'b1));
        made++;
      end else begin
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          photon_q.push_back(mk(
            $urandom_range(0, 15) != 0,
            ($urandom_range(0, 3) != 0) ? 16'($urandom_range(300, 4000)) : 16'($urandom()),
            ($urandom_range(0, 3) != 0) ? $urandom_range(0, 1240) - 620 : $urandom(),
            $urandom(),
            i == len - 1));
          made++;
        end
      end
    end
  endtask

  initial begin
    for (int k = 0; k < dps_pkg::TABLE_ENTRIES; k++) begin
      cosh_lut[k] = cosh_at(k * 4);
      omc_lut[k] = omc_at(k * 4);
    end
    m_barrel = 11'd351; m_ec_min = 11'd389; m_ec_max = 11'd607;
    m_both = 16'd400; m_lead = 16'd640; m_sub = 16'd480;
    m_mlow = 16'd1680; m_mhigh = 16'd2560;
    clear_event_state();
    for (int s = 0; s < dps_pkg::STAGES; s++) cutflow[s] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset settings
    photon_q.push_back(mk(1'b0, 16'd0, 0, 0, 1'b1));
    photon_q.push_back(mk(1'b1, 16'd1000, 0, 0, 1'b0));
    photon_q.push_back(mk(1'b1, 16'd1000, 100, 1000, 1'b1));
    photon_q.push_back(mk(1'b1, 16'd0, 10, 5, 1'b0));
    photon_q.push_back(mk(1'b1, 16'hFFFF, -2048, 2047, 1'b0));
    photon_q.push_back(mk(1'b1, 16'd800, -600, -2048, 1'b0));
    photon_q.push_back(mk(1'b1, 16'd1900, 2047, 1024, 1'b1));
    for (int i = 0; i < 17; i++)
      photon_q.push_back(mk(1'b1, 16'(500 + 37 * i), 30 * i - 240, 240 * i, i == 16));
    drain();

    random_events(250);
    drain();

    // wide open, with saturating mass
    set_all(2047, 0, 0, 0, 0, 0, 0, 65535);
    wr_reg(4'd9, 16'hFFFF);
    wr_reg(4'd15, 16'h0000);
    photon_q.push_back(mk(1'b1, 16'hFFFF, 2047, 0, 1'b0));
    photon_q.push_back(mk(1'b1, 16'hFFFF, -2048, -2048, 1'b1));
    photon_q.push_back(mk(1'b1, 16'd0, 0, 0, 1'b0));
    photon_q.push_back(mk(1'b1, 16'd0, 0, 0, 1'b1));
    random_events(250);
    drain();

    // nothing accepted
    set_all(0, 0, 0, 0, 0, 0, 0, 0);
    random_events(150);
    drain();

    // all maxed
    set_all(2047, 2047, 2047, 65535, 65535, 65535, 65535, 65535);
    random_events(150);
    drain();

    // endcap only, loose pt
    set_all(0, 100, 2047, 200, 300, 250, 500, 4000);
    random_events(200);
    drain();

    // random settings
    for (int p = 0; p < 2; p++) begin
      set_all($urandom_range(0, 700), $urandom_range(0, 500), $urandom_range(300, 2047),
              $urandom_range(0, 800), $urandom_range(0, 1500), $urandom_range(0, 1000),
              $urandom_range(0, 2000), $urandom_range(1500, 65535));
      random_events(150);
      drain();
    end

    repeat (40) @(posedge clk);
    if (fails == 0)
      $display("diphoton_event_selector_core: match");
    else
      $display("diphoton_event_selector_core: mismatch");
    $finish;
  end
endmodule
